>>> hw/rtl/itoa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and helpers of the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int ValueW     = 16;
  localparam int RadixW     = 5;
  localparam int DigitDepth = 17;
  localparam int DigitIdxW  = $clog2(DigitDepth);
  localparam int StepCntW   = $clog2(ValueW);

  localparam logic [6:0] CharZero  = 7'h30;
  localparam logic [6:0] CharNine  = 7'h39;
  localparam logic [6:0] CharSpace = 7'h20;
  localparam logic [6:0] CharMinus = 7'h2d;
  localparam logic [6:0] UpperOff  = 7'd7;
  localparam logic [6:0] LowerOff  = 7'd39;

  typedef enum logic [2:0] {
    StIdle,
    StDivide,
    StSetup,
    StPadL,
    StDigits,
    StPadR
  } state_e;

  typedef struct packed {
    logic              start;
    logic [ValueW-1:0] dividend;
    logic [RadixW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [ValueW-1:0] quot;
    logic [RadixW-1:0] rem;
  } div_rsp_t;

  function automatic logic [6:0] digit_char(input logic [RadixW-1:0] d, input logic lower);
    logic [6:0] t;
    t = CharZero + {2'b00, d};
    if (t > CharNine) begin
      t = t + (lower ? LowerOff : UpperOff);
    end
    return t;
  endfunction

endpackage

>>> hw/rtl/itoa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_div
// Bit-serial restoring divider: 16-bit dividend by a small radix, one
// quotient bit per cycle, done pulse with quotient and remainder.
// ----------------------------------------------------------------------------
module itoa_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  itoa_pkg::div_req_t  req_i,
  output itoa_pkg::div_rsp_t  rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [itoa_pkg::StepCntW-1:0] cnt_q, cnt_d;
  logic [itoa_pkg::ValueW-1:0]   quo_q, quo_d;
  logic [itoa_pkg::RadixW-1:0]   rem_q, rem_d;
  logic [itoa_pkg::RadixW-1:0]   dvs_q, dvs_d;
  logic [itoa_pkg::RadixW:0]     trial;

  // partial remainder shifted left with the next dividend bit
  assign trial = {rem_q, quo_q[itoa_pkg::ValueW-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = itoa_pkg::RadixW'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[itoa_pkg::ValueW-2:0], 1'b1};
      end else begin
        rem_d = trial[itoa_pkg::RadixW-1:0];
        quo_d = {quo_q[itoa_pkg::ValueW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == {itoa_pkg::StepCntW{1'b1}}) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

>>> hw/rtl/integer_to_ascii_formatter_top.sv
`timescale 1ns / 1ps
// Sequence: after the input transfer the divider yields one digit per division, then a setup
// step sizes the padding; the characters follow whenever the sink is ready.
// Flow: one number at a time; the bit-serial divider sets the digit time.
// Reset: rst_ni clears the sequencer, divider control and output valid at once;
// the digit buffer and payload registers are not reset.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// Formats a 16-bit value in radix 2..17 with sign, letter case and padding,
// streaming one ASCII character per output transfer.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top #(
  parameter int MAX_WIDTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [15:0]       value_i,
  input  logic signed [7:0] field_width_i,
  input  logic [3:0]        radix_minus_two_i,
  input  logic              is_signed_i,
  input  logic              lower_case_i,
  input  logic              zero_pad_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [6:0]        out_char_o,
  output logic              last_char_o
);

  localparam int PadW = $clog2(MAX_WIDTH + 1);
  localparam logic signed [7:0] MaxW = 8'(MAX_WIDTH);
  localparam logic signed [7:0] MinW = 8'(-MAX_WIDTH);

  itoa_pkg::state_e state_q, state_d;

  logic signed [7:0]                 width_q, width_d;
  logic                              lower_q, lower_d;
  logic                              zpad_q, zpad_d;
  logic                              neg_q, neg_d;
  logic [itoa_pkg::RadixW-1:0]       radix_q, radix_d;
  logic [itoa_pkg::DigitIdxW-1:0]    len_q, len_d;
  logic [itoa_pkg::DigitIdxW-1:0]    idx_q, idx_d;
  logic [PadW-1:0]                   lpad_q, lpad_d;
  logic [PadW-1:0]                   rpad_q, rpad_d;
  logic                              out_valid_q, out_valid_d;
  logic [6:0]                        out_char_q, out_char_d;
  logic                              out_last_q, out_last_d;

  logic [6:0] digit_buf_q [itoa_pkg::DigitDepth];
  logic                           buf_we;
  logic [itoa_pkg::DigitIdxW-1:0] buf_waddr;
  logic [6:0]                     buf_wdata;

  itoa_pkg::div_req_t div_req;
  itoa_pkg::div_rsp_t div_rsp;

  logic                           out_free;
  logic signed [7:0]              width_sat;
  logic                           in_neg;
  logic [itoa_pkg::DigitIdxW-1:0] len_eff;
  logic signed [8:0]              diff_l, diff_r, neg_w;

  itoa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign in_neg   = is_signed_i && value_i[15];

  always_comb begin
    if (field_width_i > MaxW) begin
      width_sat = MaxW;
    end else if (field_width_i < MinW) begin
      width_sat = MinW;
    end else begin
      width_sat = field_width_i;
    end
  end

  // pad lengths from the saturated width and the text length with sign
  assign len_eff = len_q + {{(itoa_pkg::DigitIdxW-1){1'b0}}, neg_q};
  assign diff_l  = {width_q[7], width_q} - {4'b0000, len_eff};
  assign neg_w   = 9'sd0 - {width_q[7], width_q};
  assign diff_r  = neg_w - {4'b0000, len_eff};

  always_comb begin
    state_d     = state_q;
    width_d     = width_q;
    lower_d     = lower_q;
    zpad_d      = zpad_q;
    neg_d       = neg_q;
    radix_d     = radix_q;
    len_d       = len_q;
    idx_d       = idx_q;
    lpad_d      = lpad_q;
    rpad_d      = rpad_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    buf_we      = 1'b0;
    buf_waddr   = len_q;
    buf_wdata   = itoa_pkg::CharMinus;
    div_req     = '0;
    div_req.divisor = radix_q;
    div_req.dividend = div_rsp.quot;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      itoa_pkg::StIdle: begin
        if (in_valid_i) begin
          width_d  = width_sat;
          lower_d  = lower_case_i;
          zpad_d   = zero_pad_i;
          neg_d    = in_neg;
          radix_d  = {1'b0, radix_minus_two_i} + 5'd2;
          len_d    = '0;
          div_req.start    = 1'b1;
          div_req.divisor  = {1'b0, radix_minus_two_i} + 5'd2;
          div_req.dividend = in_neg ? 16'(17'h10000 - {1'b0, value_i}) : value_i;
          state_d  = itoa_pkg::StDivide;
        end
      end
      itoa_pkg::StDivide: begin
        if (div_rsp.done) begin
          buf_we    = 1'b1;
          buf_wdata = itoa_pkg::digit_char(div_rsp.rem, lower_q);
          len_d     = len_q + 1'b1;
          if (div_rsp.quot != '0) begin
            div_req.start = 1'b1;
          end else begin
            state_d = itoa_pkg::StSetup;
          end
        end
      end
      itoa_pkg::StSetup: begin
        buf_we = neg_q;
        len_d  = len_eff;
        idx_d  = len_eff - 1'b1;
        lpad_d = (!width_q[7] && !diff_l[8] && diff_l != '0) ? diff_l[PadW-1:0] : '0;
        rpad_d = (width_q[7] && !diff_r[8] && diff_r != '0) ? diff_r[PadW-1:0] : '0;
        if (!width_q[7] && !diff_l[8] && diff_l != '0) begin
          state_d = itoa_pkg::StPadL;
        end else begin
          state_d = itoa_pkg::StDigits;
        end
      end
      itoa_pkg::StPadL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = zpad_q ? itoa_pkg::CharZero : itoa_pkg::CharSpace;
          out_last_d  = 1'b0;
          lpad_d      = lpad_q - 1'b1;
          if (lpad_q == PadW'(1)) begin
            state_d = itoa_pkg::StDigits;
          end
        end
      end
      itoa_pkg::StDigits: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = digit_buf_q[idx_q];
          out_last_d  = (idx_q == '0) && (rpad_q == '0);
          idx_d       = idx_q - 1'b1;
          if (idx_q == '0) begin
            state_d = (rpad_q != '0) ? itoa_pkg::StPadR : itoa_pkg::StIdle;
          end
        end
      end
      itoa_pkg::StPadR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = itoa_pkg::CharSpace;
          out_last_d  = (rpad_q == PadW'(1));
          rpad_d      = rpad_q - 1'b1;
          if (rpad_q == PadW'(1)) begin
            state_d = itoa_pkg::StIdle;
          end
        end
      end
      default: begin
        state_d = itoa_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itoa_pkg::StIdle;
      out_valid_q <= 1'b0;
      len_q       <= '0;
      idx_q       <= '0;
      lpad_q      <= '0;
      rpad_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      lpad_q      <= lpad_d;
      rpad_q      <= rpad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    width_q    <= width_d;
    lower_q    <= lower_d;
    zpad_q     <= zpad_d;
    neg_q      <= neg_d;
    radix_q    <= radix_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      digit_buf_q[buf_waddr] <= buf_wdata;
    end
  end

  assign in_ready_o  = (state_q == itoa_pkg::StIdle);
  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_char_o = out_last_q;

endmodule

>>> hw/rtl/itoa_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_chk
// Port-level checks of the formatter, bound to the top level.
// ----------------------------------------------------------------------------
module itoa_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [6:0]        out_char_o,
  input logic              last_char_o
);

  // a pending result stays offered until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_char_o))
    else $error("output dropped before transfer");

  // no new number while characters of the current one are still owed
  a_busy_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_char_o |-> !in_ready_o)
    else $error("input ready in the middle of a number");

  // an accepted number always keeps the input closed for the next cycle
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transfer");

  // every emitted character is printable
  a_printable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_char_o >= 7'h20 && out_char_o != 7'h7f)
    else $error("non-printable character");

endmodule

bind integer_to_ascii_formatter_top itoa_chk u_itoa_chk (.*);

>>> bench/itoa_format_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_format_checker
// Watches both channels of the integer to ASCII formatter, predicts the text
// of every accepted number and compares each character transfer in order.
// ----------------------------------------------------------------------------
module itoa_format_checker #(
  parameter int MAX_WIDTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [15:0]       value_i,
  input  logic signed [7:0] field_width_i,
  input  logic [3:0]        radix_minus_two_i,
  input  logic              is_signed_i,
  input  logic              lower_case_i,
  input  logic              zero_pad_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [6:0]        out_char_i,
  input  logic              last_char_i,
  output int                fail_count_o,
  output int                chars_pending_o
);

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } text_char_t;

  text_char_t expected_text[$];
  int         fail_count = 0;
  int         chars_pending = 0;

  assign fail_count_o    = fail_count;
  assign chars_pending_o = chars_pending;

  // appends the printed text of one number to the expected stream
  function automatic void predict_text(input logic [15:0] value, input logic signed [7:0] fw,
                                       input logic [3:0] radix_m2, input logic sgn,
                                       input logic lower, input logic zpad);
    logic [6:0]  digits[itoa_pkg::DigitDepth];
    logic [6:0]  text[$];
    logic [15:0] mag;
    logic [4:0]  radix;
    logic [6:0]  t;
    logic        neg;
    int          width;
    int          len;
    text_char_t  c;
    width = int'(fw);
    if (width > MAX_WIDTH) width = MAX_WIDTH;
    if (width < -MAX_WIDTH) width = -MAX_WIDTH;
    neg   = sgn && value[15];
    // most negative value negates to itself
    mag   = neg ? 16'(~value + 16'd1) : value;
    radix = 5'(radix_m2) + 5'd2;
    len   = 0;
    do begin
      t = 7'(mag % radix) + itoa_pkg::CharZero;
      if (t > itoa_pkg::CharNine) begin
        t = t + (lower ? itoa_pkg::LowerOff : itoa_pkg::UpperOff);
      end
      if (len < itoa_pkg::DigitDepth) begin
        digits[len] = t;
        len++;
      end
      mag = mag / radix;
    end while (mag != 0);
    if (neg && len < itoa_pkg::DigitDepth) begin
      digits[len] = itoa_pkg::CharMinus;
      len++;
    end
    // pad zeros land before the sign, as the block does
    for (int p = width - len; p > 0; p--) begin
      text.push_back(zpad ? itoa_pkg::CharZero : itoa_pkg::CharSpace);
    end
    for (int i = len - 1; i >= 0; i--) text.push_back(digits[i]);
    for (int p = -width - len; p > 0; p--) text.push_back(itoa_pkg::CharSpace);
    foreach (text[i]) begin
      c.ch   = text[i];
      c.last = (i == text.size() - 1);
      expected_text.push_back(c);
    end
  endfunction

  always @(posedge clk_i) begin : watch_channels
    text_char_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (expected_text.size() == 0) begin
          $error("unexpected character transfer: out_char %0h, last_char %0b",
                 out_char_i, last_char_i);
          fail_count++;
        end else begin
          want = expected_text.pop_front();
          if (out_char_i !== want.ch) begin
            $error("out_char: expected %0h, got %0h", want.ch, out_char_i);
            fail_count++;
          end
          if (last_char_i !== want.last) begin
            $error("last_char: expected %0b, got %0b", want.last, last_char_i);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_text(value_i, field_width_i, radix_minus_two_i, is_signed_i,
                     lower_case_i, zero_pad_i);
      end
      chars_pending <= expected_text.size();
    end
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random numbers into the integer to ASCII formatter with
// random gaps on the source and random stalls on the sink; the checker module
// predicts and compares the character stream.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WatchdogLimit = 5000;
  localparam int RandomItems   = 160;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [15:0]       value_i = '0;
  logic signed [7:0] field_width_i = '0;
  logic [3:0]        radix_minus_two_i = '0;
  logic              is_signed_i = 1'b0;
  logic              lower_case_i = 1'b0;
  logic              zero_pad_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [6:0]        out_char_o;
  logic              last_char_o;

  int fail_count;
  int chars_pending;
  int idle_cycles = 0;
  int sink_hold = 0;
  bit sink_stalls_on = 1'b1;
  bit source_gaps_on = 1'b1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  integer_to_ascii_formatter_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .value_i          (value_i),
    .field_width_i    (field_width_i),
    .radix_minus_two_i(radix_minus_two_i),
    .is_signed_i      (is_signed_i),
    .lower_case_i     (lower_case_i),
    .zero_pad_i       (zero_pad_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_char_o       (out_char_o),
    .last_char_o      (last_char_o)
  );

  itoa_format_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .value_i          (value_i),
    .field_width_i    (field_width_i),
    .radix_minus_two_i(radix_minus_two_i),
    .is_signed_i      (is_signed_i),
    .lower_case_i     (lower_case_i),
    .zero_pad_i       (zero_pad_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_char_i       (out_char_o),
    .last_char_i      (last_char_o),
    .fail_count_o     (fail_count),
    .chars_pending_o  (chars_pending)
  );

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 15);
    if (r < 12) return $urandom_range(1, 3);
    if (r < 15) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // sink stalls start on any cycle, so they hit every phase of the sequencer
  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold   <= sink_hold - 1;
      out_ready_i <= 1'b0;
    end else if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
      sink_hold   <= pick_gap() - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one number transfer, then an optional source gap
  task automatic feed_number(input logic [15:0] value, input logic signed [7:0] fw,
                             input logic [3:0] radix_m2, input logic sgn,
                             input logic lower, input logic zpad);
    int gap;
    value_i           <= value;
    field_width_i     <= fw;
    radix_minus_two_i <= radix_m2;
    is_signed_i       <= sgn;
    lower_case_i      <= lower;
    zero_pad_i        <= zpad;
    in_valid_i        <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    gap = (source_gaps_on && $urandom_range(0, 1) == 1) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    @(posedge clk_i);
    while (chars_pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] random_value();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'h0000;
          1: return 16'hffff;
          2: return 16'h8000;
          default: return 16'h7fff;
        endcase
      end
      1: return 16'($urandom_range(0, 40));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [7:0] random_width();
    case ($urandom_range(0, 9))
      0: return 8'($urandom);
      1, 2: return 8'(0 - int'($urandom_range(1, 24)));
      3, 4, 5: return 8'($urandom_range(0, 24));
      default: return 8'sd0;
    endcase
  endfunction

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes of value, width and radix, sign and pad corners
    feed_number(16'h0000, 8'sd0, 4'd8, 1'b0, 1'b0, 1'b0);
    feed_number(16'hffff, 8'sd0, 4'd0, 1'b0, 1'b0, 1'b0);
    feed_number(16'h8000, 8'sd0, 4'd8, 1'b1, 1'b0, 1'b0);
    feed_number(16'h8000, 8'sd0, 4'd0, 1'b1, 1'b0, 1'b0);
    feed_number(16'hfffb, 8'sd5, 4'd8, 1'b1, 1'b0, 1'b1);
    feed_number(16'hfffb, 8'sd5, 4'd8, 1'b1, 1'b0, 1'b0);
    feed_number(16'hfffb, -8'sd3, 4'd8, 1'b1, 1'b0, 1'b0);
    feed_number(16'd1234, -8'sd64, 4'd8, 1'b0, 1'b0, 1'b0);
    feed_number(16'd1234, 8'sd64, 4'd8, 1'b0, 1'b0, 1'b1);
    feed_number(16'h00ff, 8'sd127, 4'd14, 1'b0, 1'b1, 1'b1);
    feed_number(16'h00ff, 8'h80, 4'd14, 1'b0, 1'b0, 1'b0);
    feed_number(16'd12345, 8'sd2, 4'd8, 1'b0, 1'b0, 1'b1);
    feed_number(16'd16, 8'sd0, 4'd15, 1'b0, 1'b0, 1'b0);
    feed_number(16'd16, 8'sd0, 4'd15, 1'b0, 1'b1, 1'b0);
    feed_number(16'habcd, 8'sd0, 4'd14, 1'b0, 1'b0, 1'b0);
    feed_number(16'habcd, 8'sd6, 4'd14, 1'b0, 1'b1, 1'b1);
    feed_number(16'h7fff, 8'sd0, 4'd6, 1'b1, 1'b0, 1'b0);
    feed_number(16'd42, 8'sd4, 4'd8, 1'b1, 1'b0, 1'b1);
    feed_number(16'h0000, 8'sd1, 4'd8, 1'b1, 1'b0, 1'b1);
    feed_number(16'hffff, 8'sd10, 4'd15, 1'b0, 1'b1, 1'b1);
    feed_number(16'hffff, 8'sd0, 4'd1, 1'b0, 1'b0, 1'b0);
    feed_number(16'hffff, -8'sd8, 4'd8, 1'b1, 1'b1, 1'b1);

    for (int n = 0; n < RandomItems; n++) begin
      // change idling in phases, one without sink stalls and one without source gaps
      if (n % 40 == 0) begin
        sink_stalls_on = (n / 40) != 1;
        source_gaps_on = (n / 40) != 2;
      end
      if (n == RandomItems / 2) begin
        // let the block run dry once
        in_valid_i <= 1'b0;
        wait_for_results();
      end
      feed_number(random_value(), random_width(), 4'($urandom_range(0, 15)),
                  1'($urandom), 1'($urandom), 1'($urandom));
    end
    in_valid_i <= 1'b0;

    wait_for_results();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
